FILE: rtl/core/cldr_pkg.sv
// package for the character lcd dirty cell refresher
// holds screen geometry, row base addresses, field codes and payload types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cldr_pkg;

   // screen geometry
   localparam int COLUMNS = 20;
   localparam int ROWS    = 4;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

   // cursor address command base for each display row
   localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

   // item kinds
   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // register select on the result
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [4:0] column;
      logic [2:0] row;
      logic [7:0] character;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/core/char_lcd_dirty_cell_refresher_core.sv
// top level of the character lcd dirty cell refresher
// shadow screen buffer with dirty scan, cursor tracking and output register
// depends on cldr_pkg
`timescale 1ns / 1ps
`default_nettype none

// Shadow screen for a COLUMNS x ROWS character display (20 x 4). A store
// transfer writes one character into a cell and marks it dirty; stores outside
// the screen are dropped. A refresh tick scans from a wrapping pointer, one
// cell per cycle through the read port of the cell buffer, for at most
// COLUMNS cells. At the first dirty cell it returns either a cursor address
// command (when the cell does not directly follow the last cell sent; the
// pointer then stays) or the character (the dirty mark is cleared and the
// pointer moves on). A tick with nothing dirty in reach returns nothing.
// Flow: a store does not stall the input. A tick holds the input while it
// reads the buffer cell by cell up to the first dirty cell and then delivers
// the result; the delivery stretches while an earlier result is still
// stalled in the output register. A tick that finds nothing returns to idle
// after COLUMNS cells. The result sits in an output register, so the next
// item is taken while it waits. After reset no clearing pass is needed:
// per-cell valid flops mark the buffer entries ever written.

module char_lcd_dirty_cell_refresher_core
   import cldr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic [4:0] col;
      logic [1:0] row;
   } ptr_type;

   typedef struct packed {
      logic       dirty;
      logic [7:0] character;
   } cell_type;

   // next cell in raster order, wrapping at the screen end
   function automatic ptr_type advance(input ptr_type p);
      ptr_type n;
      n = p;
      if (p.col == 5'(COLUMNS - 1)) begin
         n.col = '0;
         n.row = (p.row == 2'(ROWS - 1)) ? 2'd0 : p.row + 2'd1;
      end else begin
         n.col = p.col + 5'd1;
      end
      return n;
   endfunction

   function automatic logic [CELL_W-1:0] cell_addr(input logic [4:0] col,
                                                   input logic [2:0] row);
      int a;
      a = int'(row) * COLUMNS + int'(col);
      return CELL_W'(a);
   endfunction

   // cell buffer and its per-entry written flags
   cell_type           mem [CELLS];
   logic [CELLS-1:0]   valid_ff;
   cell_type           rd_cell_ff;
   logic               rd_valid_ff;

   logic               mem_wr_en;
   logic [CELL_W-1:0]  mem_wr_addr;
   cell_type           mem_wr_data;
   logic               mem_rd_en;
   logic [CELL_W-1:0]  mem_rd_addr;
   logic               valid_set_en;

   // control and payload registers
   state_type          state_ff, state_in;
   ptr_type            scan_ff, scan_in;      // cell under evaluation
   ptr_type            rd_ptr_ff, rd_ptr_in;  // next cell to read, one ahead
   logic [4:0]         count_ff, count_in;    // cells evaluated in this tick
   logic [5:0]         sent_col_ff, sent_col_in;
   logic [2:0]         sent_row_ff, sent_row_in;
   rsp_payload_type    pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               out_free;
   logic               hit;
   logic               follows;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = rd_valid_ff && rd_cell_ff.dirty;
   assign follows   = (sent_row_ff == {1'b0, scan_ff.row}) &&
                      ((sent_col_ff + 6'd1) == {1'b0, scan_ff.col});

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      rd_ptr_in      = rd_ptr_ff;
      count_in       = count_ff;
      sent_col_in    = sent_col_ff;
      sent_row_in    = sent_row_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = cell_addr(req_payload.column, req_payload.row);
      mem_wr_data    = '{dirty: 1'b1, character: req_payload.character};
      mem_rd_en      = 1'b0;
      mem_rd_addr    = cell_addr(scan_ff.col, {1'b0, scan_ff.row});
      valid_set_en   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.kind == KIND_STORE) begin
                  // off-screen stores change nothing
                  if ((req_payload.column < 5'(COLUMNS)) &&
                      (req_payload.row < 3'(ROWS))) begin
                     mem_wr_en    = 1'b1;
                     valid_set_en = 1'b1;
                  end
               end else begin
                  // start the scan: first read at the pointer
                  mem_rd_en = 1'b1;
                  rd_ptr_in = advance(scan_ff);
                  count_in  = '0;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               sent_row_in = {1'b0, scan_ff.row};
               if (!follows) begin
                  // cursor command, pointer stays on this cell
                  pend_in.out_byte = ROW_BASE[scan_ff.row] + {3'b000, scan_ff.col};
                  pend_in.is_data  = RS_COMMAND;
                  sent_col_in      = {1'b0, scan_ff.col} - 6'd1;
               end else begin
                  // character out, clear the dirty mark in place
                  pend_in.out_byte = rd_cell_ff.character;
                  pend_in.is_data  = RS_DATA;
                  sent_col_in      = {1'b0, scan_ff.col};
                  mem_wr_en        = 1'b1;
                  mem_wr_addr      = cell_addr(scan_ff.col, {1'b0, scan_ff.row});
                  mem_wr_data      = '{dirty: 1'b0, character: rd_cell_ff.character};
                  scan_in          = advance(scan_ff);
               end
               state_in = ST_DELIVER;
            end else begin
               scan_in = rd_ptr_ff;
               if (count_ff == 5'(COLUMNS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  // keep one read in flight ahead of evaluation
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = cell_addr(rd_ptr_ff.col, {1'b0, rd_ptr_ff.row});
                  rd_ptr_in   = advance(rd_ptr_ff);
                  count_in    = count_ff + 5'd1;
               end
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = pend_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         sent_col_ff  <= '1;
         sent_row_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         sent_col_ff  <= sent_col_in;
         sent_row_ff  <= sent_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff        <= pend_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // written flags: an entry never written reads as clean
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (valid_set_en) begin
         valid_ff[mem_wr_addr] <= 1'b1;
      end
   end

   // cell buffer, one write and one registered read per cycle; the fsm never
   // reads and writes in the same cycle, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_cell_ff  <= mem[mem_rd_addr];
         rd_valid_ff <= valid_ff[mem_rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/cldr_checker.sv
// port-level checker for the character lcd dirty cell refresher
// bound to char_lcd_dirty_cell_refresher_core; depends on cldr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cldr_checker
   import cldr_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_payload_type req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   logic seen_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_rsp_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         seen_rsp_ff <= 1'b1;
      end
   end

   // no result is left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // the first byte after reset positions the cursor
   a_first_is_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !seen_rsp_ff |-> rsp_payload.is_data == RS_COMMAND)
      else $error("first result is not a cursor command");

   // every cursor command carries the set-address bit
   a_cmd_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_data == RS_COMMAND |-> rsp_payload.out_byte[7])
      else $error("cursor command without set-address bit");

   // a tick transfer starts a scan, which holds off the next request
   a_tick_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.kind == KIND_TICK |=> req_stall)
      else $error("tick transfer did not start a scan");

endmodule

bind char_lcd_dirty_cell_refresher_core cldr_checker u_cldr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
